/* design/dhrf_pkg.sv */
package dhrf_pkg;

  // Sliding window length in positions.
  localparam int WINDOW     = 500;
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int MIN_W      = 9;
  localparam int GAP_W      = 10;
  localparam int CMP_W      = (CNT_W > MIN_W) ? CNT_W : MIN_W;
  localparam int POS_W      = 31;
  localparam int REF_W      = 32;
  localparam int HIT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // A region starts two windows back from the position where it opens.
  localparam logic [POS_W-1:0] START_BACK = POS_W'(2 * WINDOW);
  localparam logic [POS_W:0]   END_AHEAD  = (POS_W + 1)'(WINDOW);

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANY_MIN   = 2'd0,
    CFG_ALL_MIN   = 2'd1,
    CFG_MERGE_GAP = 2'd2
  } cfg_idx_e;

  // One position after the window stage.
  typedef struct packed {
    logic             good;
    logic [POS_W-1:0] start_cand;
    logic [POS_W-1:0] end_cand;
    logic [POS_W-1:0] len;
    logic [REF_W-1:0] ref_id;
    logic             last;
  } item_t;

  // One region word on its way out.
  typedef struct packed {
    logic [REF_W-1:0] rref;
    logic [POS_W-1:0] rstart;
    logic [POS_W-1:0] rend;
    logic             rlast;
  } region_t;

endpackage

/* design/dhrf_cell.sv */
module dhrf_cell
  import dhrf_pkg::*;
(
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [1:0] d_i,
  output logic [1:0] q_o
);

  logic [1:0] flags_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_q <= d_i;
    end
  end

  assign q_o = flags_q;

endmodule

/* design/dhrf_window.sv */
module dhrf_window
  import dhrf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [HIT_W-1:0] hit_bits_i,
  input  logic [REF_W-1:0] ref_id_i,
  input  logic [POS_W-1:0] ref_length_i,
  input  logic             end_of_ref_i,
  input  logic [MIN_W-1:0] any_min_i,
  input  logic [MIN_W-1:0] all_min_i,
  input  logic             adv_i,
  output logic             item_valid_o,
  output item_t            item_o
);

  logic [1:0]       tap [WINDOW];
  logic             accept;
  logic             any_new;
  logic             all_new;
  logic             full;
  logic [CNT_W-1:0] any_cnt_q, any_cnt_d;
  logic [CNT_W-1:0] all_cnt_q, all_cnt_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             valid_q, valid_d;
  item_t            item_q, item_d;
  logic [POS_W:0]   end_wide;

  assign in_stall_o = valid_q && !adv_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign any_new    = (hit_bits_i != '0);
  assign all_new    = (hit_bits_i == '1);
  assign full       = (fill_q == CNT_W'(WINDOW));

  // The flag history is a shift line: the word accepted WINDOW items ago
  // sits in the last cell when the next one arrives.
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_head
      dhrf_cell u_cell (
        .clk_i (clk_i),
        .en_i  (accept),
        .d_i   ({all_new, any_new}),
        .q_o   (tap[k])
      );
    end else begin : g_body
      dhrf_cell u_cell (
        .clk_i (clk_i),
        .en_i  (accept),
        .d_i   (tap[k-1]),
        .q_o   (tap[k])
      );
    end
  end

  always_comb begin
    any_cnt_d = any_cnt_q - CNT_W'(full && tap[WINDOW-1][0]) + CNT_W'(any_new);
    all_cnt_d = all_cnt_q - CNT_W'(full && tap[WINDOW-1][1]) + CNT_W'(all_new);
    end_wide  = {1'b0, pos_q} + END_AHEAD;

    item_d.good = (CMP_W'(any_cnt_d) >= CMP_W'(any_min_i)) &&
                  (CMP_W'(all_cnt_d) >= CMP_W'(all_min_i));
    item_d.start_cand = (pos_q < START_BACK + POS_W'(1)) ? POS_W'(1) : pos_q - START_BACK;
    item_d.end_cand   = (end_wide > {1'b0, ref_length_i}) ? ref_length_i
                                                          : end_wide[POS_W-1:0];
    item_d.len    = ref_length_i;
    item_d.ref_id = ref_id_i;
    item_d.last   = end_of_ref_i;

    if (end_of_ref_i) begin
      fill_d = '0;
      pos_d  = '0;
    end else begin
      fill_d = full ? fill_q : fill_q + CNT_W'(1);
      pos_d  = pos_q + POS_W'(1);
    end

    if (accept) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_cnt_q <= '0;
      all_cnt_q <= '0;
      fill_q    <= '0;
      pos_q     <= '0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (accept) begin
        if (end_of_ref_i) begin
          any_cnt_q <= '0;
          all_cnt_q <= '0;
        end else begin
          any_cnt_q <= any_cnt_d;
          all_cnt_q <= all_cnt_d;
        end
        fill_q <= fill_d;
        pos_q  <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

`ifndef ASSERT_OFF
  a_any_le_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_cnt_q <= fill_q)
    else $error("any-hit count exceeds the number of positions in the window");

  a_all_le_any : assert property (@(posedge clk_i) disable iff (!rst_ni)
    all_cnt_q <= any_cnt_q)
    else $error("all-hit count exceeds any-hit count");
`endif

endmodule

/* design/dhrf_region.sv */
module dhrf_region
  import dhrf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  item_t            item_i,
  input  logic [GAP_W-1:0] merge_gap_i,
  output logic [1:0]       push_cnt_o,
  output region_t          slot0_o,
  output region_t          slot1_o
);

  logic             in_q;
  logic [POS_W-1:0] open_start_q, open_start_d;
  logic             held_valid_q, held_valid_d;
  logic [POS_W-1:0] held_start_q, held_start_d;
  logic [POS_W-1:0] held_end_q, held_end_d;

  logic             in_mid;
  logic             close;
  logic             commit;
  logic [POS_W-1:0] c_start;
  logic [POS_W-1:0] c_end;
  logic [POS_W+1:0] diff;
  logic             merge;
  logic             emit_old;
  logic             emit_held;
  region_t          r_old;
  region_t          r_held;

  always_comb begin
    in_mid    = in_q || item_i.good;
    close     = in_q && !item_i.good;
    commit    = close || (item_i.last && in_mid);
    c_start   = in_q ? open_start_q : item_i.start_cand;
    c_end     = close ? item_i.end_cand : item_i.len;
    diff      = {2'b00, c_start} - {2'b00, held_end_q};
    merge     = held_valid_q && ($signed(diff) < $signed((POS_W + 2)'(merge_gap_i)));
    emit_old  = commit && held_valid_q && !merge;

    held_valid_d = held_valid_q || commit;
    held_start_d = (commit && !merge) ? c_start : held_start_q;
    held_end_d   = commit ? c_end : held_end_q;
    open_start_d = (!in_q && item_i.good) ? item_i.start_cand : open_start_q;

    emit_held = item_i.last && held_valid_d;

    r_old.rref    = item_i.ref_id;
    r_old.rstart  = held_start_q;
    r_old.rend    = held_end_q;
    r_old.rlast   = !emit_held;
    r_held.rref   = item_i.ref_id;
    r_held.rstart = held_start_d;
    r_held.rend   = held_end_d;
    r_held.rlast  = 1'b1;

    push_cnt_o = 2'(emit_old) + 2'(emit_held);
    slot0_o    = emit_old ? r_old : r_held;
    slot1_o    = r_held;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q         <= 1'b0;
      held_valid_q <= 1'b0;
    end else if (adv_i) begin
      if (item_i.last) begin
        in_q         <= 1'b0;
        held_valid_q <= 1'b0;
      end else begin
        in_q         <= item_i.good;
        held_valid_q <= held_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      open_start_q <= open_start_d;
      held_start_q <= held_start_d;
      held_end_q   <= held_end_d;
    end
  end

`ifndef ASSERT_OFF
  a_two_words_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && push_cnt_o == 2'd2) |-> (!slot0_o.rlast && slot1_o.rlast && item_i.last))
    else $error("two region words from one position are out of order");
`endif

endmodule

/* design/dhrf_outq.sv */
module dhrf_outq
  import dhrf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  region_t    slot0_i,
  input  region_t    slot1_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output region_t    out_o
);

  region_t             mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_q, rd_q;
  logic [OQ_CNT_W-1:0] cnt_q;
  logic [OQ_PTR_W-1:0] wr_next;
  logic                pop;

  assign wr_next     = wr_q + OQ_PTR_W'(1);
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (cnt_q <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign out_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + OQ_PTR_W'(push_cnt_i);
      rd_q  <= rd_q + OQ_PTR_W'(pop);
      cnt_q <= cnt_q + OQ_CNT_W'(push_cnt_i) - OQ_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= slot0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_next] <= slot1_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OQ_CNT_W'(OQ_DEPTH))
    else $error("output queue overflow");

  a_push_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt_i != 2'd0) |-> room_o)
    else $error("region words pushed without room in the output queue");
`endif

endmodule

/* design/dense_hit_region_finder.sv */
// Dense hit region finder. Each input word is one reference position, in
// order from position 0, with three coder-hit bits; end_of_ref_i marks the
// final position of a reference and returns all per-reference state to its
// start. A 500-stage shift line of flag cells keeps the any-hit and all-hit
// flags of the window, and two running counters add the new flags and drop
// the flags that leave the window. A region opens when both counts reach
// their configured minimums (start two windows back, at least 1) and closes
// when they fail (end one window ahead, at most the reference length). A
// closed region that starts less than merge_gap after the held region's end
// extends it; otherwise the held region is sent and the new one is held.
// The block takes one word per clock cycle for as long as the output side
// keeps up. A result word passes through the window stage register and a
// four-entry output queue; the region stage between them is combinational.
// A position can produce two result words (only at the end of a reference);
// the region stage passes a position on only while the queue has at least
// two free entries, so with the output side stalled the input is held off
// once three result words are waiting and the window stage holds a position.
// The configuration port writes any_hit_min (index 0), all_hit_min (index 1)
// and merge_gap (index 2, reset 200); other indexes are ignored. Write it
// only while no words are in flight. There is no clearing pass after reset.
module dense_hit_region_finder
  import dhrf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [HIT_W-1:0]      hit_bits_i,
  input  logic [REF_W-1:0]      ref_id_i,
  input  logic [POS_W-1:0]      ref_length_i,
  input  logic                  end_of_ref_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [REF_W-1:0]      region_ref_o,
  output logic [POS_W-1:0]      region_start_o,
  output logic [POS_W-1:0]      region_end_o,
  output logic                  run_last_o
);

  logic [MIN_W-1:0] any_min_q;
  logic [MIN_W-1:0] all_min_q;
  logic [GAP_W-1:0] merge_gap_q;

  logic       item_valid;
  item_t      item;
  logic       room;
  logic       adv;
  logic [1:0] push_cnt;
  region_t    slot0;
  region_t    slot1;
  region_t    out_word;

  // Configuration registers; values are cut to the register widths.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_min_q   <= '0;
      all_min_q   <= '0;
      merge_gap_q <= GAP_W'(200);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ANY_MIN:   any_min_q   <= cfg_data_i[MIN_W-1:0];
        CFG_ALL_MIN:   all_min_q   <= cfg_data_i[MIN_W-1:0];
        CFG_MERGE_GAP: merge_gap_q <= cfg_data_i[GAP_W-1:0];
        default:       ;
      endcase
    end
  end

  // The region stage takes a position only when the queue can hold the two
  // words it may produce.
  assign adv = item_valid && room;

  dhrf_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hit_bits_i   (hit_bits_i),
    .ref_id_i     (ref_id_i),
    .ref_length_i (ref_length_i),
    .end_of_ref_i (end_of_ref_i),
    .any_min_i    (any_min_q),
    .all_min_i    (all_min_q),
    .adv_i        (adv),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  dhrf_region u_region (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .item_i      (item),
    .merge_gap_i (merge_gap_q),
    .push_cnt_o  (push_cnt),
    .slot0_o     (slot0),
    .slot1_o     (slot1)
  );

  dhrf_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (adv ? push_cnt : 2'd0),
    .slot0_i     (slot0),
    .slot1_i     (slot1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_word)
  );

  assign region_ref_o   = out_word.rref;
  assign region_start_o = out_word.rstart;
  assign region_end_o   = out_word.rend;
  assign run_last_o     = out_word.rlast;

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dhrf_pkg::*;

  // The clock runs at 50 MHz.
  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 7;
  // A result word leaves the block through the window stage register and the
  // output queue; the pad after the wait lets a word with no result settle.
  localparam int SETTLE_PAD = 8;
  localparam int DRAIN_MAX = 20000;
  localparam int ITEM_GOAL = 1500;
  // The long back-pressure stretch on the result side, in cycles.
  localparam int HOLD_CYCLES = 300;
  // One-position references sent while the result side is held off.
  localparam int HOLD_REFS = 60;
  localparam int PRINT_CAP = 50;
  // The index that no register answers to.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // One position word as the sender presents it.
  typedef struct {
    logic [HIT_W-1:0] hits;
    logic [REF_W-1:0] rid;
    logic [POS_W-1:0] len;
    logic             last;
  } pos_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [HIT_W-1:0]      hit_bits = '0;
  logic [REF_W-1:0]      ref_id = '0;
  logic [POS_W-1:0]      ref_length = '0;
  logic                  end_of_ref = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [REF_W-1:0]      region_ref;
  logic [POS_W-1:0]      region_start;
  logic [POS_W-1:0]      region_end;
  logic                  run_last;

  dense_hit_region_finder dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .hit_bits_i     (hit_bits),
    .ref_id_i       (ref_id),
    .ref_length_i   (ref_length),
    .end_of_ref_i   (end_of_ref),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .region_ref_o   (region_ref),
    .region_start_o (region_start),
    .region_end_o   (region_end),
    .run_last_o     (run_last)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Region predictor. It keeps its own copy of the registers and of the
  // per-reference state, and turns every accepted position word into the
  // region words that the block must send for it.
  // ---------------------------------------------------------------------------
  logic [MIN_W-1:0] min_any = '0;
  logic [MIN_W-1:0] min_all = '0;
  logic [GAP_W-1:0] gap_cfg = GAP_W'(200);

  // Window flags per slot: bit 0 is any-hit, bit 1 is all-hit.
  logic [1:0]       slide_flags [WINDOW];
  logic [CNT_W-1:0] cnt_any = '0;
  logic [CNT_W-1:0] cnt_all = '0;
  logic [POS_W-1:0] cur_pos = '0;
  logic [POS_W-1:0] open_begin = '0;
  logic [POS_W-1:0] pend_begin = '0;
  logic [POS_W-1:0] pend_end = '0;
  int unsigned      slot = 0;
  bit               window_full = 1'b0;
  bit               region_open = 1'b0;
  bit               pend_valid = 1'b0;

  region_t   fresh_regions[$];
  region_t   regions_due[$];
  pos_word_t words_to_send[$];
  int        err_count = 0;

  // Idling controls of the sender and the receiver.
  bit no_idle = 1'b0;
  bit want_hold = 1'b0;
  int gap_left = 0;
  int run_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= PRINT_CAP) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
  endtask

  // Sends the held region out, tagged with the reference of the current word.
  task automatic send_held(input logic [REF_W-1:0] rid);
    region_t r;
    r.rref = rid;
    r.rstart = pend_begin;
    r.rend = pend_end;
    r.rlast = 1'b0;
    fresh_regions.insert(fresh_regions.size(), r);
  endtask

  // A closed region either stretches the held one, when it starts less than
  // the merge gap after the held end (a signed distance), or pushes the held
  // one out and takes its place.
  task automatic close_region(input logic [REF_W-1:0] rid, input logic [POS_W-1:0] s,
                              input logic [POS_W-1:0] e);
    if (pend_valid && (longint'(s) - longint'(pend_end) < longint'(gap_cfg))) begin
      pend_end = e;
    end else begin
      if (pend_valid) begin
        send_held(rid);
      end
      pend_begin = s;
      pend_end = e;
      pend_valid = 1'b1;
    end
  endtask

  task automatic note_position(input logic [HIT_W-1:0] hits, input logic [REF_W-1:0] rid,
                               input logic [POS_W-1:0] len, input logic last);
    logic [1:0] leaving;
    bit         dense_now;
    longint     reach;
    fresh_regions.delete();
    // Nothing leaves the window until it has been filled once for this
    // reference, so only slots written for this reference are ever read.
    if (window_full) begin
      leaving = slide_flags[slot];
      cnt_any -= CNT_W'(leaving[0]);
      cnt_all -= CNT_W'(leaving[1]);
    end
    cnt_any += CNT_W'(|hits);
    cnt_all += CNT_W'(&hits);
    slide_flags[slot] = {&hits, |hits};
    slot++;
    if (slot == WINDOW) begin
      slot = 0;
      window_full = 1'b1;
    end
    // With both minimums at zero every window passes.
    dense_now = (cnt_any >= min_any) && (cnt_all >= min_all);
    if (!region_open && dense_now) begin
      // The start lies two windows back, but never before position 1.
      if (cur_pos <= POS_W'(2 * WINDOW)) begin
        open_begin = POS_W'(1);
      end else begin
        open_begin = cur_pos - POS_W'(2 * WINDOW);
      end
      region_open = 1'b1;
    end
    if (region_open && !dense_now) begin
      // The end lies one window ahead, clamped to the reference length (which
      // may be zero or shorter than the real number of positions).
      reach = longint'(cur_pos) + WINDOW;
      if (reach > longint'(len)) begin
        reach = longint'(len);
      end
      close_region(rid, open_begin, POS_W'(reach));
      region_open = 1'b0;
    end
    if (last) begin
      // A region still open at the end of a reference ends at its length, and
      // whatever is held goes out. Then the reference state starts over; the
      // registers keep their values.
      if (region_open) begin
        close_region(rid, open_begin, len);
      end
      if (pend_valid) begin
        send_held(rid);
      end
      cnt_any = '0;
      cnt_all = '0;
      cur_pos = '0;
      open_begin = '0;
      pend_begin = '0;
      pend_end = '0;
      slot = 0;
      window_full = 1'b0;
      region_open = 1'b0;
      pend_valid = 1'b0;
    end else begin
      // The position wraps at 31 bits by the width of cur_pos.
      cur_pos = cur_pos + POS_W'(1);
    end
    if (fresh_regions.size() != 0) begin
      fresh_regions[fresh_regions.size() - 1].rlast = 1'b1;
    end
    foreach (fresh_regions[k]) begin
      regions_due.insert(regions_due.size(), fresh_regions[k]);
    end
  endtask

  // Idle stretch length: mostly none, often short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. A word stays on the port until the block takes it; after each
  // accepted word a random gap may pass before the next one is offered.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : send_words
    pos_word_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        note_position(hit_bits, ref_id, ref_length, end_of_ref);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (words_to_send.size() != 0) begin
          nxt = words_to_send.pop_front();
          hit_bits <= nxt.hits;
          ref_id <= nxt.rid;
          ref_length <= nxt.len;
          end_of_ref <= nxt.last;
          in_valid <= 1'b1;
          gap_left = no_idle ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long hold-off. Once the stretch of short references is under way, the
  // result side is held off for a long stretch while the sender keeps offering
  // words, so the output queue fills and the block has to stall its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (want_hold && !hold_done && in_valid) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. Every accepted region word is checked field by field against the
  // oldest prediction. The stall pattern alternates short free runs with
  // random stalls, on top of the long hold-off above.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : take_regions
    region_t want;
    bit      busy;
    if (!rst_n) begin
      out_stall <= 1'b0;
      run_left = 0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (regions_due.size() == 0) begin
          report_mismatch($sformatf("unexpected region word ref %h start %0d end %0d",
                                    region_ref, region_start, region_end));
        end else begin
          want = regions_due.pop_front();
          if (region_ref !== want.rref) begin
            report_mismatch($sformatf("region_ref %h, predicted %h", region_ref, want.rref));
          end
          if (region_start !== want.rstart) begin
            report_mismatch($sformatf("region_start %0d, predicted %0d",
                                      region_start, want.rstart));
          end
          if (region_end !== want.rend) begin
            report_mismatch($sformatf("region_end %0d, predicted %0d", region_end, want.rend));
          end
          if (run_last !== want.rlast) begin
            report_mismatch($sformatf("run_last %b, predicted %b", run_last, want.rlast));
          end
        end
      end
      busy = 1'b0;
      if (run_left != 0) begin
        run_left--;
      end else if (stall_left != 0) begin
        stall_left--;
        busy = 1'b1;
      end else begin
        run_left = $urandom_range(1, 12);
        stall_left = no_idle ? 0 : idle_len();
      end
      out_stall <= busy || (hold_left > 1);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and configuration.
  // ---------------------------------------------------------------------------
  int words_made = 0;

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    // The 9-bit registers drop the top data bit.
    case (idx)
      CFG_ANY_MIN: begin
        min_any = val[MIN_W-1:0];
      end
      CFG_ALL_MIN: begin
        min_all = val[MIN_W-1:0];
      end
      CFG_MERGE_GAP: begin
        gap_cfg = val[GAP_W-1:0];
      end
      default: begin
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_word(input logic [HIT_W-1:0] hits, input logic [REF_W-1:0] rid,
                          input logic [POS_W-1:0] len, input logic last);
    pos_word_t w;
    w.hits = hits;
    w.rid = rid;
    w.len = len;
    w.last = last;
    words_to_send.insert(words_to_send.size(), w);
    words_made++;
  endtask

  // One reference of n positions built from dense and sparse stretches. The
  // length field is sometimes the true count, sometimes any value up to 600
  // (so that ends may clamp early) and sometimes any 31-bit value. A few
  // references are noisy: their id and length change from word to word.
  task automatic add_reference(input int n, input bit finish);
    logic [REF_W-1:0] rid;
    logic [POS_W-1:0] len;
    logic [HIT_W-1:0] hits;
    bit               noisy;
    bit               dense;
    int               seg;
    rid = $urandom;
    case ($urandom_range(0, 3))
      0, 1: len = POS_W'(n);
      2: len = POS_W'($urandom_range(0, 600));
      default: len = POS_W'($urandom);
    endcase
    noisy = ($urandom_range(0, 9) == 0);
    seg = 0;
    dense = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (seg == 0) begin
        seg = $urandom_range(20, 250);
        dense = ($urandom_range(0, 1) == 1);
      end
      seg--;
      if (dense) begin
        hits = ($urandom_range(0, 9) < 7) ? HIT_W'(7) : HIT_W'($urandom_range(0, 7));
      end else begin
        hits = ($urandom_range(0, 9) < 8) ? HIT_W'(0) : HIT_W'($urandom_range(1, 7));
      end
      if (noisy && $urandom_range(0, 3) == 0) begin
        rid = $urandom;
        len = POS_W'($urandom);
      end
      add_word(hits, rid, len, finish && (k == n - 1));
    end
  endtask

  function automatic logic [GAP_W-1:0] pick_gap();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return GAP_W'(1);
      2: return '1;
      default: return GAP_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // Waits until every word has been taken and every predicted region word has
  // arrived, then lets the pipeline empty of words that cause no result.
  task automatic settle();
    int waited;
    waited = 0;
    while (waited < DRAIN_MAX &&
           (words_to_send.size() != 0 || in_valid || regions_due.size() != 0)) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_PAD) @(negedge clk);
  endtask

  initial begin
    int          n_refs;
    int          n;
    bit          long_phase;
    logic [MIN_W-1:0] any_val;
    logic [MIN_W-1:0] all_val;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Registers at their reset values: with both minimums at zero every
    // window passes, so each reference yields one region from position 1 to
    // its length. Field extremes: all-ones id and length, zero id and length.
    add_word(HIT_W'(7), '1, '1, 1'b1);
    add_word(HIT_W'(0), '0, '0, 1'b1);
    add_word(HIT_W'(1), REF_W'(32'h5a5a5a5a), POS_W'(1), 1'b0);
    add_word(HIT_W'(2), REF_W'(32'h5a5a5a5a), POS_W'(1), 1'b0);
    add_word(HIT_W'(4), REF_W'(32'ha5a5a5a5), POS_W'(1), 1'b1);
    settle();

    // Minimums out of reach, written with the top data bit set so that the
    // masking shows; the unused index must change nothing.
    write_reg(CFG_ANY_MIN, '1);
    write_reg(CFG_ALL_MIN, '1);
    write_reg(CFG_UNUSED, '1);
    add_word(HIT_W'(7), REF_W'(32'h0000_0001), POS_W'(5), 1'b0);
    add_word(HIT_W'(7), REF_W'(32'h0000_0001), POS_W'(5), 1'b1);
    settle();

    // Small minimums: the region opens only once an all-hit position comes in.
    write_reg(CFG_ANY_MIN, CFG_DATA_W'(2));
    write_reg(CFG_ALL_MIN, CFG_DATA_W'(1));
    write_reg(CFG_MERGE_GAP, '1);
    add_word(HIT_W'(0), REF_W'(32'h8000_0000), POS_W'(4), 1'b0);
    add_word(HIT_W'(3), REF_W'(32'h8000_0000), POS_W'(4), 1'b0);
    add_word(HIT_W'(5), REF_W'(32'h8000_0000), POS_W'(4), 1'b0);
    add_word(HIT_W'(6), REF_W'(32'h8000_0000), POS_W'(4), 1'b0);
    add_word(HIT_W'(7), REF_W'(32'h8000_0000), POS_W'(4), 1'b0);
    add_word(HIT_W'(0), REF_W'(32'h8000_0000), POS_W'(4), 1'b1);
    settle();

    write_reg(CFG_ANY_MIN, CFG_DATA_W'(1));
    write_reg(CFG_ALL_MIN, '0);
    write_reg(CFG_MERGE_GAP, '0);
    add_word(HIT_W'(0), REF_W'(32'h0000_ffff), POS_W'(2), 1'b0);
    add_word(HIT_W'(0), REF_W'(32'h0000_ffff), POS_W'(2), 1'b0);
    add_word(HIT_W'(1), REF_W'(32'h0000_ffff), POS_W'(2), 1'b0);
    add_word(HIT_W'(0), REF_W'(32'h0000_ffff), POS_W'(2), 1'b0);
    add_word(HIT_W'(0), REF_W'(32'h0000_ffff), POS_W'(2), 1'b1);
    settle();

    // Hold-off stretch: with both minimums at zero every one-position
    // reference yields one region word, so while the result side is held off
    // the output queue fills and the block stalls its input.
    write_reg(CFG_ANY_MIN, '0);
    write_reg(CFG_ALL_MIN, '0);
    no_idle = 1'b0;
    want_hold = 1'b1;
    for (int k = 0; k < HOLD_REFS; k++) begin
      add_word(HIT_W'($urandom_range(0, 7)), REF_W'($urandom),
               POS_W'($urandom_range(0, 700)), 1'b1);
    end
    settle();

    // Random phases. A long phase runs one reference well past the window so
    // that regions close, merge or get pushed out; a short phase runs several
    // brief references under mostly small minimums. The first random phase is long.
    long_phase = 1'b1;
    while (words_made < ITEM_GOAL) begin
      if (long_phase) begin
        any_val = MIN_W'($urandom_range(60, 320));
        all_val = MIN_W'($urandom_range(15, 180));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: any_val = '0;
          9: any_val = $urandom_range(0, 1) ? MIN_W'(500) : '1;
          default: any_val = MIN_W'($urandom_range(1, 25));
        endcase
        all_val = ($urandom_range(0, 2) == 0) ? '0 : MIN_W'($urandom_range(1, 8));
      end
      write_reg(CFG_ANY_MIN, {1'($urandom_range(0, 1)), any_val});
      write_reg(CFG_ALL_MIN, {1'($urandom_range(0, 1)), all_val});
      write_reg(CFG_MERGE_GAP, pick_gap());
      if ($urandom_range(0, 7) == 0) begin
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
      end
      no_idle = ($urandom_range(0, 3) == 0);
      if (long_phase) begin
        add_reference($urandom_range(520, 1000), 1'b1);
      end else begin
        n_refs = $urandom_range(3, 8);
        for (int r = 0; r < n_refs; r++) begin
          n = ($urandom_range(0, 4) == 0) ? $urandom_range(31, 200) : $urandom_range(1, 30);
          // Now and then the phase ends inside a reference, which then runs on
          // under the next register setting.
          add_reference(n, (r != n_refs - 1) || ($urandom_range(0, 9) != 0));
        end
      end
      settle();
      long_phase = ($urandom_range(0, 9) < 3);
    end

    settle();
    while (regions_due.size() != 0) begin
      report_mismatch($sformatf("predicted region %0d..%0d never arrived",
                                regions_due[0].rstart, regions_due[0].rend));
      void'(regions_due.pop_front());
    end
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Backstop for a hung block: far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* dense_hit_region_finder.f */
design/dhrf_pkg.sv
design/dhrf_cell.sv
design/dhrf_window.sv
design/dhrf_region.sv
design/dhrf_outq.sv
design/dense_hit_region_finder.sv
verif/tb_top.sv
